>>> design/ppoc_pkg.sv
// ---------------------------------------------------------------------------
// ppoc_pkg
// Shared types and constants for the pad port origin calibrator.
// ---------------------------------------------------------------------------
package ppoc_pkg;

    localparam int PORT_COUNT = 4;
    localparam int SLOT_COUNT = 4;
    localparam int AXES       = 6;
    localparam int STICKS     = 4;
    localparam int TRIGS      = 2;

    localparam logic [2:0] NO_SLOT    = 3'd4;
    localparam logic [3:0] PROBE_MASK = 4'h9;

    localparam logic [1:0] PH_PROBE  = 2'd0;
    localparam logic [1:0] PH_ORIGIN = 2'd1;
    localparam logic [1:0] PH_RUN    = 2'd2;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_FOREIGN = 2'd2;

    localparam logic REG_SETTLE_POLLS = 1'b0;
    localparam logic REG_MISS_LIMIT   = 1'b1;

    localparam logic [3:0] SETTLE_RESET = 4'd8;
    localparam logic [3:0] MISS_RESET   = 4'd10;

    typedef logic [AXES-1:0][7:0] reading_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] port;
        logic       port_ok;
        logic       probe_hit;
        logic       reply_ok;
        reading_t   rd;
    } item_t;

    typedef struct packed {
        logic [1:0] port;
        logic [1:0] phase;
        logic [2:0] slot;
        reading_t   rep;
        logic       go;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> design/ppoc_front.sv
// ---------------------------------------------------------------------------
// ppoc_front
// Input stage: registers a request and classifies it for the back end.
// ---------------------------------------------------------------------------
module ppoc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [71:0]            in_data,
    input  logic                   in_op,
    input  ppoc_pkg::queue_status_t q_status,
    output logic                   push,
    output ppoc_pkg::item_t        push_item
);

    logic            valid_reg;
    ppoc_pkg::item_t item_reg;
    ppoc_pkg::item_t item_next;
    logic            port_ok;

    assign port_ok  = ({1'b0, in_data[1:0]} < 3'(ppoc_pkg::PORT_COUNT));
    assign push     = valid_reg && !q_status.full;
    assign in_ready = !valid_reg || !q_status.full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.port      = in_data[1:0];
        item_next.port_ok   = port_ok;
        item_next.probe_hit = |(in_data[5:2] & ppoc_pkg::PROBE_MASK);
        item_next.reply_ok  = in_data[17];
        for (int i = 0; i < ppoc_pkg::AXES; i++)
        begin
            item_next.rd[i] = in_data[18 + 8*i +: 8];
        end
        if (in_op)
            item_next.kind = ppoc_pkg::KIND_TICK;
        else if (port_ok)
            item_next.kind = ppoc_pkg::KIND_REPLY;
        else
            item_next.kind = ppoc_pkg::KIND_FOREIGN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> design/ppoc_queue.sv
// ---------------------------------------------------------------------------
// ppoc_queue
// Two-entry queue between the classifier and the executor.
// ---------------------------------------------------------------------------
module ppoc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ppoc_pkg::item_t         push_item,
    input  logic                    pop,
    output ppoc_pkg::item_t         pop_item,
    output ppoc_pkg::queue_status_t status
);

    ppoc_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/ppoc_back.sv
// ---------------------------------------------------------------------------
// ppoc_back
// Executor: per-port phase state, calibration, reports and output register.
// ---------------------------------------------------------------------------
module ppoc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [3:0]              cfg_data,
    input  ppoc_pkg::queue_status_t q_status,
    input  ppoc_pkg::item_t         item,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ppoc_pkg::result_t       result
);

    localparam int P = ppoc_pkg::PORT_COUNT;

    logic [3:0] settle_polls_reg;
    logic [3:0] miss_limit_reg;
    logic [3:0] settle_reg;
    logic [3:0] settle_next;

    logic [1:0] phase_reg  [P];
    logic [2:0] slot_reg   [P];
    logic [3:0] miss_reg   [P];
    logic [8:0] stick_reg  [P][ppoc_pkg::STICKS];
    logic [8:0] trig_reg   [P][ppoc_pkg::TRIGS];
    ppoc_pkg::reading_t rep_reg [P];

    logic [1:0]         phase_next;
    logic [2:0]         slot_next;
    logic [3:0]         miss_next;
    logic [ppoc_pkg::STICKS-1:0][8:0] stick_next;
    logic [ppoc_pkg::TRIGS-1:0][8:0]  trig_next;
    ppoc_pkg::reading_t rep_next;
    logic               go;
    logic               write_port;

    logic               out_valid_reg;
    ppoc_pkg::result_t  result_reg;
    ppoc_pkg::result_t  result_next;

    logic [ppoc_pkg::SLOT_COUNT-1:0] used;
    logic [2:0]  free_slot;
    logic [1:0]  p;
    logic [3:0]  miss_inc;
    logic signed [9:0] sum [ppoc_pkg::AXES];

    assign p         = item.port;
    assign pop       = !q_status.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign miss_inc  = miss_reg[p] + 4'd1;

    always_comb
    begin
        for (int s = 0; s < ppoc_pkg::SLOT_COUNT; s++)
        begin
            used[s] = 1'b0;
            for (int q = 0; q < P; q++)
            begin
                if (slot_reg[q] == 3'(s))
                    used[s] = 1'b1;
            end
        end
        free_slot = 3'd0;
        for (int s = ppoc_pkg::SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (!used[s])
                free_slot = 3'(s);
        end
    end

    always_comb
    begin
        for (int i = 0; i < ppoc_pkg::STICKS; i++)
        begin
            sum[i] = $signed({2'b00, item.rd[i]}) + $signed({stick_reg[p][i][8], stick_reg[p][i]});
        end
        for (int i = 0; i < ppoc_pkg::TRIGS; i++)
        begin
            sum[ppoc_pkg::STICKS + i] = $signed({2'b00, item.rd[ppoc_pkg::STICKS + i]})
                + $signed({trig_reg[p][i][8], trig_reg[p][i]});
        end
    end

    always_comb
    begin
        phase_next  = phase_reg[p];
        slot_next   = slot_reg[p];
        miss_next   = miss_reg[p];
        rep_next    = rep_reg[p];
        for (int i = 0; i < ppoc_pkg::STICKS; i++)
            stick_next[i] = stick_reg[p][i];
        for (int i = 0; i < ppoc_pkg::TRIGS; i++)
            trig_next[i] = trig_reg[p][i];
        settle_next = settle_reg;
        go          = 1'b0;
        write_port  = 1'b0;

        unique case (item.kind)
            ppoc_pkg::KIND_TICK:
            begin
                if (settle_reg != 4'd0)
                    settle_next = settle_reg - 4'd1;
                else
                    go = 1'b1;
            end
            ppoc_pkg::KIND_REPLY:
            begin
                write_port = 1'b1;
                case (phase_reg[p])
                    ppoc_pkg::PH_PROBE:
                    begin
                        if (item.probe_hit)
                        begin
                            settle_next = settle_polls_reg;
                            phase_next  = ppoc_pkg::PH_ORIGIN;
                        end
                    end
                    ppoc_pkg::PH_ORIGIN:
                    begin
                        if (!item.reply_ok)
                        begin
                            phase_next = ppoc_pkg::PH_PROBE;
                            slot_next  = ppoc_pkg::NO_SLOT;
                        end
                        else
                        begin
                            for (int i = 0; i < ppoc_pkg::STICKS; i++)
                                stick_next[i] = 9'd128 - {1'b0, item.rd[i]};
                            for (int i = 0; i < ppoc_pkg::TRIGS; i++)
                                trig_next[i] = 9'd0 - {1'b0, item.rd[ppoc_pkg::STICKS + i]};
                            rep_next   = item.rd;
                            phase_next = ppoc_pkg::PH_RUN;
                            slot_next  = free_slot;
                        end
                    end
                    ppoc_pkg::PH_RUN:
                    begin
                        if (!item.reply_ok)
                        begin
                            miss_next = miss_inc;
                            if (miss_inc >= miss_limit_reg)
                            begin
                                phase_next = ppoc_pkg::PH_PROBE;
                                slot_next  = ppoc_pkg::NO_SLOT;
                                miss_next  = 4'd0;
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < ppoc_pkg::AXES; i++)
                            begin
                                if (sum[i] < 0)
                                    rep_next[i] = 8'd0;
                                else if (sum[i] > 10'sd255)
                                    rep_next[i] = 8'd255;
                                else
                                    rep_next[i] = sum[i][7:0];
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        result_next.port = p;
        result_next.go   = go;
        if (item.port_ok)
        begin
            result_next.phase = phase_next;
            result_next.slot  = slot_next;
            result_next.rep   = rep_next;
        end
        else
        begin
            result_next.phase = ppoc_pkg::PH_PROBE;
            result_next.slot  = ppoc_pkg::NO_SLOT;
            result_next.rep   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_polls_reg <= ppoc_pkg::SETTLE_RESET;
            miss_limit_reg   <= ppoc_pkg::MISS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ppoc_pkg::REG_SETTLE_POLLS)
                settle_polls_reg <= cfg_data;
            else if (cfg_index == ppoc_pkg::REG_MISS_LIMIT)
                miss_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg    <= 4'd0;
            out_valid_reg <= 1'b0;
            for (int q = 0; q < P; q++)
            begin
                phase_reg[q] <= ppoc_pkg::PH_PROBE;
                slot_reg[q]  <= ppoc_pkg::NO_SLOT;
                miss_reg[q]  <= 4'd0;
                rep_reg[q]   <= '0;
                for (int i = 0; i < ppoc_pkg::STICKS; i++)
                    stick_reg[q][i] <= 9'd0;
                for (int i = 0; i < ppoc_pkg::TRIGS; i++)
                    trig_reg[q][i] <= 9'd0;
            end
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                settle_reg    <= settle_next;
                if (write_port)
                begin
                    phase_reg[p] <= phase_next;
                    slot_reg[p]  <= slot_next;
                    miss_reg[p]  <= miss_next;
                    rep_reg[p]   <= rep_next;
                    for (int i = 0; i < ppoc_pkg::STICKS; i++)
                        stick_reg[p][i] <= stick_next[i];
                    for (int i = 0; i < ppoc_pkg::TRIGS; i++)
                        trig_reg[p][i] <= trig_next[i];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> design/pad_port_origin_calibrator.sv
// ---------------------------------------------------------------------------
// pad_port_origin_calibrator
// Game-pad port manager: probe, origin calibration and clamped run reports
// for four controller ports.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata readings, tuser op
//   m_axis    out  tvalid/tready           tdata report
//   cfg       in   cfg_we                  cfg_index, cfg_data
//
// One request per cycle sustained while the receiver takes results; a request
// passes through the input register, the queue and the output register.
// Reset clears all port state; registers return to settle 8, miss limit 10.
// Each side stalls on its own through the two-entry queue; the executor
// holds a finished result in its output register until it is taken.
// ---------------------------------------------------------------------------
module pad_port_origin_calibrator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // port[1:0], probe_bits[16:2], reply_ok[17], left_x_in[25:18],
    // left_y_in[33:26], right_x_in[41:34], right_y_in[49:42],
    // trig_l_in[57:50], trig_r_in[65:58], zero[71:66]
    input  logic [71:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // port_out[1:0], phase_out[3:2], slot_out[6:4], left_x_out[14:7],
    // left_y_out[22:15], right_x_out[30:23], right_y_out[38:31],
    // trig_l_out[46:39], trig_r_out[54:47], poll_go[55]
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    ppoc_pkg::queue_status_t q_status;
    ppoc_pkg::item_t         push_item;
    ppoc_pkg::item_t         pop_item;
    ppoc_pkg::result_t       result;
    logic                    push;
    logic                    pop;

    ppoc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    ppoc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    ppoc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .item      (pop_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {result.go,
                           result.rep[5], result.rep[4], result.rep[3],
                           result.rep[2], result.rep[1], result.rep[0],
                           result.slot, result.phase, result.port};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the pad port origin calibrator. A directed pass
// walks ports through probe, origin and run (clamps, misses, slot handout,
// settle countdown), then random requests run under several register
// settings, with random stalls on both sides in all but the last one. A
// scoreboard class predicts every report and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
module testbench;

    localparam logic OP_REPLY = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    localparam int   ITEMS_PER_PHASE = 280;
    localparam int   HOLD_CYCLES     = 80;
    localparam int   STUCK_LIMIT     = 2000;

    typedef struct packed {
        logic                           op;
        logic [1:0]                     port;
        logic [14:0]                    probe;
        logic                           ok;
        logic [ppoc_pkg::AXES-1:0][7:0] rd;
    } pad_request_t;

    typedef struct packed {
        logic [1:0]                     port;
        logic [1:0]                     phase;
        logic [2:0]                     slot;
        logic [ppoc_pkg::AXES-1:0][7:0] rep;
        logic                           go;
    } pad_report_t;

    class pad_scoreboard;
        logic [3:0]  settle_polls;
        logic [3:0]  miss_limit;
        logic [1:0]  phase [ppoc_pkg::PORT_COUNT];
        logic [2:0]  slot [ppoc_pkg::PORT_COUNT];
        int          offset [ppoc_pkg::PORT_COUNT][ppoc_pkg::AXES];
        logic [7:0]  level [ppoc_pkg::PORT_COUNT][ppoc_pkg::AXES];
        logic [3:0]  misses [ppoc_pkg::PORT_COUNT];
        logic [3:0]  settle_left;
        pad_report_t expected_q [$];
        int          errors;
        string       axis_name [ppoc_pkg::AXES] = '{"left_x_out", "left_y_out",
                                                    "right_x_out", "right_y_out",
                                                    "trig_l_out", "trig_r_out"};

        function new();
            settle_polls = ppoc_pkg::SETTLE_RESET;
            miss_limit   = ppoc_pkg::MISS_RESET;
            for (int p = 0; p < ppoc_pkg::PORT_COUNT; p++)
            begin
                phase[p]  = ppoc_pkg::PH_PROBE;
                slot[p]   = ppoc_pkg::NO_SLOT;
                misses[p] = 4'd0;
                for (int a = 0; a < ppoc_pkg::AXES; a++)
                begin
                    offset[p][a] = 0;
                    level[p][a]  = 8'd0;
                end
            end
            settle_left = 4'd0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(pad_request_t r);
            pad_report_t e;
            int          p;
            int          v;
            logic [3:0]  c;
            logic        used;
            logic [2:0]  chosen;
            p    = int'(r.port);
            e.go = 1'b0;
            if (r.op == OP_TICK)
            begin
                if (settle_left > 0)
                    settle_left = settle_left - 4'd1;
                else
                    e.go = 1'b1;
            end
            else
            begin
                case (phase[p])
                    ppoc_pkg::PH_PROBE:
                    begin
                        if ((r.probe[3:0] & ppoc_pkg::PROBE_MASK) != 4'd0)
                        begin
                            settle_left = settle_polls;
                            phase[p]    = ppoc_pkg::PH_ORIGIN;
                        end
                    end
                    ppoc_pkg::PH_ORIGIN:
                    begin
                        if (!r.ok)
                        begin
                            phase[p] = ppoc_pkg::PH_PROBE;
                            slot[p]  = ppoc_pkg::NO_SLOT;
                        end
                        else
                        begin
                            for (int a = 0; a < ppoc_pkg::AXES; a++)
                            begin
                                offset[p][a] = (a < ppoc_pkg::STICKS) ? 128 - int'(r.rd[a])
                                                                      : -int'(r.rd[a]);
                                level[p][a]  = r.rd[a];
                            end
                            // lowest slot nobody holds, slot 0 when all are taken
                            chosen = 3'd0;
                            for (int s = ppoc_pkg::SLOT_COUNT - 1; s >= 0; s--)
                            begin
                                used = 1'b0;
                                for (int q = 0; q < ppoc_pkg::PORT_COUNT; q++)
                                    if (slot[q] == 3'(s))
                                        used = 1'b1;
                                if (!used)
                                    chosen = 3'(s);
                            end
                            slot[p]  = chosen;
                            phase[p] = ppoc_pkg::PH_RUN;
                        end
                    end
                    ppoc_pkg::PH_RUN:
                    begin
                        if (!r.ok)
                        begin
                            c = misses[p] + 4'd1;
                            if (c >= miss_limit)
                            begin
                                phase[p] = ppoc_pkg::PH_PROBE;
                                slot[p]  = ppoc_pkg::NO_SLOT;
                                c        = 4'd0;
                            end
                            misses[p] = c;
                        end
                        else
                        begin
                            for (int a = 0; a < ppoc_pkg::AXES; a++)
                            begin
                                v = int'(r.rd[a]) + offset[p][a];
                                level[p][a] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            e.port  = r.port;
            e.phase = phase[p];
            e.slot  = slot[p];
            for (int a = 0; a < ppoc_pkg::AXES; a++)
                e.rep[a] = level[p][a];
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, int expv, int gotv);
            if (expv != gotv)
            begin
                $error("%s: expected %0d, actual %0d", name, expv, gotv);
                errors++;
            end
        endfunction

        function void check_result(logic [55:0] d);
            pad_report_t e;
            if (expected_q.size() == 0)
            begin
                $error("report with no request outstanding: tdata %h", d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("port_out", int'(e.port), int'(d[1:0]));
            compare_field("phase_out", int'(e.phase), int'(d[3:2]));
            compare_field("slot_out", int'(e.slot), int'(d[6:4]));
            for (int a = 0; a < ppoc_pkg::AXES; a++)
                compare_field(axis_name[a], int'(e.rep[a]), int'(d[7 + 8 * a +: 8]));
            compare_field("poll_go", int'(e.go), int'(d[55]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    pad_scoreboard sb;
    bit            hold_off;
    bit            calm;
    int            stuck_cycles;

    pad_port_origin_calibrator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    function automatic pad_request_t mk(logic op, logic [1:0] port, logic [14:0] probe,
                                        logic ok, logic [ppoc_pkg::AXES-1:0][7:0] rd);
        pad_request_t r;
        r.op    = op;
        r.port  = port;
        r.probe = probe;
        r.ok    = ok;
        r.rd    = rd;
        return r;
    endfunction

    function automatic pad_request_t random_request();
        pad_request_t r;
        r.op    = ($urandom_range(0, 99) < 15) ? OP_TICK : OP_REPLY;
        r.port  = 2'($urandom_range(0, 3));
        r.probe = 15'($urandom_range(0, 32767));
        r.ok    = ($urandom_range(0, 99) < 85);
        for (int a = 0; a < ppoc_pkg::AXES; a++)
        begin
            case ($urandom_range(0, 9))
                0:       r.rd[a] = 8'd0;
                1:       r.rd[a] = 8'd255;
                default: r.rd[a] = 8'($urandom_range(0, 255));
            endcase
        end
        return r;
    endfunction

    task automatic push_request(input pad_request_t r);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, r.rd, r.ok, r.probe, r.port};
        s_axis_tuser  <= r.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(r);
    endtask

    task automatic sender_gap(input int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending and wait until every report is back
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == ppoc_pkg::REG_SETTLE_POLLS)
            sb.settle_polls = val;
        else
            sb.miss_limit = val;
    endtask

    // receiver: random stall bursts, ready stretches, one long hold-off
    initial
    begin
        int stall_left;
        int ready_left;
        stall_left = 0;
        ready_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (ready_left > 0)
            begin
                m_axis_tready <= 1'b1;
                ready_left--;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(1, 40) - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] settle_set [5];
        logic [3:0] limit_set [5];
        sb            = new();
        hold_off      = 1'b0;
        calm          = 1'b0;
        stuck_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_REPLY;
        cfg_we        = 1'b0;
        cfg_index     = ppoc_pkg::REG_SETTLE_POLLS;
        cfg_data      = 4'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(ppoc_pkg::REG_SETTLE_POLLS, 4'd2);
        write_reg(ppoc_pkg::REG_MISS_LIMIT, 4'd2);

        // directed walk through the phases
        push_request(mk(OP_TICK,  2'd0, 15'h0000, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h7FF6, 1'b1, {6{8'd255}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0008, 1'b1, {6{8'd0}}));
        push_request(mk(OP_TICK,  2'd3, 15'h7FFF, 1'b0, {6{8'd255}}));
        push_request(mk(OP_TICK,  2'd0, 15'h0000, 1'b1, {6{8'd0}}));
        push_request(mk(OP_TICK,  2'd1, 15'h0000, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b0, {6{8'd7}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0001, 1'b0, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b1, {6{8'd255}}));
        push_request(mk(OP_REPLY, 2'd1, 15'h7FFF, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd1, 15'h0000, 1'b1, {6{8'd255}}));
        push_request(mk(OP_REPLY, 2'd1, 15'h0000, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd1, 15'h0000, 1'b1, {6{8'd128}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b0, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b0, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd2, 15'h0009, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd2, 15'h0000, 1'b1, 48'h0102_7F80_81FE));
        push_request(mk(OP_REPLY, 2'd3, 15'h4001, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd3, 15'h0000, 1'b1, 48'hFE81_807F_0201));
        push_request(mk(OP_REPLY, 2'd0, 15'h0008, 1'b1, {6{8'd0}}));
        push_request(mk(OP_REPLY, 2'd0, 15'h0000, 1'b1, {6{8'd64}}));
        push_request(mk(OP_TICK,  2'd2, 15'h0000, 1'b1, {6{8'd0}}));
        drain_block();

        settle_set = '{4'd0, 4'd15, 4'd7, 4'($urandom_range(0, 15)), 4'd8};
        limit_set  = '{4'd1, 4'd15, 4'd3, 4'($urandom_range(1, 15)), 4'd10};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(ppoc_pkg::REG_SETTLE_POLLS, settle_set[ph]);
            write_reg(ppoc_pkg::REG_MISS_LIMIT, limit_set[ph]);
            calm = (ph == 4);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 1 && i == 40)
                    hold_off = 1'b1;
                if (ph == 2 && i == 120)
                    drain_block();
                if (!calm && (i % 100) < 60 && $urandom_range(0, 4) == 0)
                    sender_gap($urandom_range(1, 14));
                push_request(random_request());
            end
            drain_block();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
